@@ src/lpbs_pkg.sv @@
`default_nettype none

package lpbs_pkg;

  // Width of one color channel of a stored pixel.
  localparam int unsigned COLOR_W = 8;

  // One stored pixel: the three color channels kept side by side in one word.
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  // Request kinds as carried on in_tuser.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SCALE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

endpackage

`default_nettype wire

@@ src/led_panel_bitplane_store.sv @@
// Frame store for an RGB LED panel driven by a scanning shift chain.
// Input channel: in_tuser carries the request kind (write pixel, read pin byte,
// scale brightness, clear all) and in_tdata the pixel, read and scale fields.
// A transaction is taken when in_tvalid and in_tready are both high.
// Output channel: one 8-bit pin byte per read request, held in an output
// register until out_tready takes it; all other requests give no result.
// Flow: a pixel write is stored at the edge that accepts it. A read fetches
// the two pixels of the row pair through the two read ports of the pixel
// memory into its read registers; S_RD_DATA then moves the byte into the
// output register. If that register still holds an untaken byte, the read
// waits in S_RD_DATA and in_tready stays low. A scale request walks the
// memory through a read, multiply, write-back pipeline at one pixel a cycle,
// then drains it. A clear request writes zeros at one pixel a cycle.
// Reset: after rst_n is released the same clearing pass runs over all
// PANEL_SIZE*PANEL_SIZE pixels with in_tready low; the output register
// comes up empty.
`default_nettype none

module led_panel_bitplane_store #(
  parameter int unsigned PANEL_SIZE = 64,
  parameter int unsigned SCAN_ROWS  = 16,
  parameter int unsigned PLANES     = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input transaction.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  // [5:0] x, [11:6] y, [19:12] red, [27:20] green, [35:28] blue,
  // [38:36] plane, [42:39] scan_row, [49:43] chain_column,
  // [57:50] brightness, [63:58] zero
  input  wire logic [63:0] in_tdata,
  // Result transaction.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] pin_byte
  output logic [7:0]       out_tdata
);

  localparam int unsigned DEPTH = PANEL_SIZE * PANEL_SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Pin positions inside the pin byte.
  localparam int unsigned PIN_R1 = 1;
  localparam int unsigned PIN_R2 = 2;
  localparam int unsigned PIN_B1 = 3;
  localparam int unsigned PIN_B2 = 4;
  localparam int unsigned PIN_G1 = 5;
  localparam int unsigned PIN_G2 = 7;

  localparam logic signed [9:0] P_S     = 10'(PANEL_SIZE);
  localparam logic signed [9:0] ROWS_S  = 10'(SCAN_ROWS);
  localparam logic [3:0]        PLANES_U = 4'(PLANES);
  localparam logic [5:0]        ROWS_U  = 6'(SCAN_ROWS);
  localparam logic [8:0]        CHAIN_U = 9'(2 * PANEL_SIZE);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_DATA,
    S_SCALE,
    S_DRAIN
  } state_t;

  // Field unpacking.
  lpbs_pkg::req_t f_req;
  logic [5:0] f_x;
  logic [5:0] f_y;
  logic [7:0] f_red;
  logic [7:0] f_green;
  logic [7:0] f_blue;
  logic [2:0] f_plane;
  logic [3:0] f_srow;
  logic [6:0] f_col;
  logic [7:0] f_bright;

  assign f_req    = lpbs_pkg::req_t'(in_tuser);
  assign f_x      = in_tdata[5:0];
  assign f_y      = in_tdata[11:6];
  assign f_red    = in_tdata[19:12];
  assign f_green  = in_tdata[27:20];
  assign f_blue   = in_tdata[35:28];
  assign f_plane  = in_tdata[38:36];
  assign f_srow   = in_tdata[42:39];
  assign f_col    = in_tdata[49:43];
  assign f_bright = in_tdata[57:50];

  state_t        state_r;
  logic [AW-1:0] sweep_idx_r;
  logic [7:0]    k_r;
  logic [2:0]    plane_r;
  logic          ok_up_r;
  logic          ok_lo_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic          out_tvalid_r;
  logic [7:0]    out_tdata_r;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Geometry of a pin byte read: which two pixels feed it.
  logic signed [9:0] c_s;
  logic signed [9:0] r_s;
  logic signed [9:0] col_s;
  logic signed [9:0] up_s;
  logic signed [9:0] lo_s;
  logic              req_ok;
  logic              col_ok;
  logic              ok_up;
  logic              ok_lo;
  logic [AW-1:0]     up_addr;
  logic [AW-1:0]     lo_addr;

  always_comb begin
    c_s = $signed({3'b000, f_col});
    r_s = $signed({6'b000000, f_srow});
    if (c_s >= P_S) begin
      col_s = c_s - P_S;
      up_s  = r_s;
      lo_s  = r_s + ROWS_S;
    end else begin
      // The left half of the chain runs mirrored: columns and rows count down.
      col_s = P_S - 10'sd1 - c_s;
      up_s  = P_S - 10'sd1 - r_s;
      lo_s  = P_S - 10'sd1 - ROWS_S - r_s;
    end
    req_ok = ({1'b0, f_plane} < PLANES_U) && ({2'b00, f_srow} < ROWS_U) &&
             ({2'b00, f_col} < CHAIN_U);
    col_ok = (col_s >= 10'sd0) && (col_s < P_S);
    ok_up  = req_ok && col_ok && (up_s >= 10'sd0) && (up_s < P_S);
    ok_lo  = req_ok && col_ok && (lo_s >= 10'sd0) && (lo_s < P_S);
    up_addr = AW'(int'(up_s) * int'(PANEL_SIZE) + int'(col_s));
    lo_addr = AW'(int'(lo_s) * int'(PANEL_SIZE) + int'(col_s));
  end

  // Pixel write address and on-panel check.
  logic          px_ok;
  logic [AW-1:0] px_addr;

  assign px_ok   = ($signed({4'b0000, f_x}) < P_S) && ($signed({4'b0000, f_y}) < P_S);
  assign px_addr = AW'(int'(f_y) * int'(PANEL_SIZE) + int'(f_x));

  // Memory ports.
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  lpbs_pkg::rgb_t mem_wr_data;
  logic           rd_a_en;
  logic [AW-1:0]  rd_a_addr;
  lpbs_pkg::rgb_t rd_a_data;
  logic           rd_b_en;
  lpbs_pkg::rgb_t rd_b_data;

  logic           scl_wr_en;
  logic [AW-1:0]  scl_wr_addr;
  lpbs_pkg::rgb_t scl_wr_data;

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = sweep_idx_r;
    mem_wr_data = '0;
    rd_a_en     = 1'b0;
    rd_a_addr   = up_addr;
    rd_b_en     = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      S_IDLE: begin
        mem_wr_en         = in_acc && (f_req == lpbs_pkg::REQ_WRITE) && px_ok;
        mem_wr_addr       = px_addr;
        mem_wr_data.red   = f_red;
        mem_wr_data.green = f_green;
        mem_wr_data.blue  = f_blue;
        rd_a_en           = in_acc && (f_req == lpbs_pkg::REQ_READ);
        rd_b_en           = in_acc && (f_req == lpbs_pkg::REQ_READ);
      end
      S_SCALE: begin
        mem_wr_en   = scl_wr_en;
        mem_wr_addr = scl_wr_addr;
        mem_wr_data = scl_wr_data;
        rd_a_en     = 1'b1;
        rd_a_addr   = sweep_idx_r;
      end
      default: begin
        mem_wr_en   = scl_wr_en;
        mem_wr_addr = scl_wr_addr;
        mem_wr_data = scl_wr_data;
      end
    endcase
  end

  lpbs_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (lo_addr),
    .rd_b_data (rd_b_data)
  );

  lpbs_scaler #(
    .AW (AW)
  ) u_scaler (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .in_addr (rd_addr_r),
    .in_pix  (rd_a_data),
    .k       (k_r),
    .wr_en   (scl_wr_en),
    .wr_addr (scl_wr_addr),
    .wr_data (scl_wr_data)
  );

  // Pin byte assembled from the two fetched pixels.
  logic [7:0] pin_nxt;

  always_comb begin
    pin_nxt         = '0;
    pin_nxt[PIN_R1] = ok_up_r && rd_a_data.red[plane_r];
    pin_nxt[PIN_G1] = ok_up_r && rd_a_data.green[plane_r];
    pin_nxt[PIN_B1] = ok_up_r && rd_a_data.blue[plane_r];
    pin_nxt[PIN_R2] = ok_lo_r && rd_b_data.red[plane_r];
    pin_nxt[PIN_G2] = ok_lo_r && rd_b_data.green[plane_r];
    pin_nxt[PIN_B2] = ok_lo_r && rd_b_data.blue[plane_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      sweep_idx_r  <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_vld_r  <= (state_r == S_SCALE);
      rd_addr_r <= sweep_idx_r;
      // A read that is finishing refills the output register itself below.
      if (out_tvalid_r && out_tready && (state_r != S_RD_DATA)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (sweep_idx_r == LAST_ADDR) begin
            sweep_idx_r <= '0;
            state_r     <= S_IDLE;
          end else begin
            sweep_idx_r <= sweep_idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            plane_r <= f_plane;
            ok_up_r <= ok_up;
            ok_lo_r <= ok_lo;
            k_r     <= f_bright;
            case (f_req)
              lpbs_pkg::REQ_READ:  state_r <= S_RD_DATA;
              lpbs_pkg::REQ_SCALE: state_r <= S_SCALE;
              lpbs_pkg::REQ_CLEAR: state_r <= S_CLEAR;
              default:             state_r <= S_IDLE;
            endcase
          end
        end
        S_RD_DATA: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= pin_nxt;
            state_r      <= S_IDLE;
          end
        end
        S_SCALE: begin
          if (sweep_idx_r == LAST_ADDR) begin
            sweep_idx_r <= '0;
            state_r     <= S_DRAIN;
          end else begin
            sweep_idx_r <= sweep_idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // Wait for the last pixels to leave the multiply pipeline.
          if (!rd_vld_r && !scl_wr_en) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  // A scaled write-back never lands on the pixel being fetched in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (scl_wr_en && rd_a_en) |-> (scl_wr_addr != rd_a_addr))
    else $error("scale write-back collides with a read of the same pixel");

  // New requests are taken only once the scale pipeline has emptied.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_vld_r && !scl_wr_en))
    else $error("scale pipeline still busy in idle");

  // Every sweep leaves its address counter at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (sweep_idx_r == '0))
    else $error("sweep counter not at zero in idle");

  // A result appears only at the end of a pin byte read.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_RD_DATA))
    else $error("result produced outside a read");
`endif

endmodule

`default_nettype wire

@@ src/lpbs_frame_mem.sv @@
`default_nettype none

// Pixel memory: one write port, two read ports, read data registered.
module lpbs_frame_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire lpbs_pkg::rgb_t wr_data,
  input  wire logic          rd_a_en,
  input  wire logic [AW-1:0] rd_a_addr,
  output lpbs_pkg::rgb_t     rd_a_data,
  input  wire logic          rd_b_en,
  input  wire logic [AW-1:0] rd_b_addr,
  output lpbs_pkg::rgb_t     rd_b_data
);

  lpbs_pkg::rgb_t mem [DEPTH];
  lpbs_pkg::rgb_t rd_a_data_r;
  lpbs_pkg::rgb_t rd_b_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while a port is not enabled.
  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data_r <= mem[rd_b_addr];
    end
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

`default_nettype wire

@@ src/lpbs_scaler.sv @@
`default_nettype none

// Brightness scaler: v * k / 255 for each channel. The products are registered,
// then the divide by 255 is done as (p + (p >> 8) + 1) >> 8, which is exact for
// every product of two 8-bit values.
module lpbs_scaler #(
  parameter int unsigned AW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [AW-1:0] in_addr,
  input  wire lpbs_pkg::rgb_t in_pix,
  input  wire logic [7:0]    k,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output lpbs_pkg::rgb_t     wr_data
);

  logic          vld_r;
  logic [AW-1:0] addr_r;
  logic [15:0]   prod_r_r;
  logic [15:0]   prod_g_r;
  logic [15:0]   prod_b_r;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= in_addr;
    prod_r_r <= {8'd0, in_pix.red}   * {8'd0, k};
    prod_g_r <= {8'd0, in_pix.green} * {8'd0, k};
    prod_b_r <= {8'd0, in_pix.blue}  * {8'd0, k};
  end

  assign wr_en         = vld_r;
  assign wr_addr       = addr_r;
  assign wr_data.red   = div255(prod_r_r);
  assign wr_data.green = div255(prod_g_r);
  assign wr_data.blue  = div255(prod_b_r);

endmodule

`default_nettype wire

@@ test/tb_led_panel_bitplane_store.sv @@
`timescale 1ns / 1ps

module tb_led_panel_bitplane_store;

  // Panel geometry, matching the default parameters of the block.
  localparam int PANEL_SIZE  = 64;
  localparam int SCAN_ROWS   = 16;
  localparam int PLANES      = 5;
  localparam int STORE_DEPTH = PANEL_SIZE * PANEL_SIZE;

  // Bit positions of the color pins inside one pin byte.
  localparam int PIN_R1 = 1;
  localparam int PIN_R2 = 2;
  localparam int PIN_B1 = 3;
  localparam int PIN_B2 = 4;
  localparam int PIN_G1 = 5;
  localparam int PIN_G2 = 7;

  // CYCLE_LIMIT lies well above the length of a correct run, counting the
  // clearing pass after reset, every sweep, and the longest gaps and stalls.
  localparam int CYCLE_LIMIT = 1000000;

  // One request with all of its fields; the kind decides which ones matter.
  typedef struct {
    lpbs_pkg::req_t kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] plane;
    logic [3:0] scan_row;
    logic [6:0] chain_column;
    logic [7:0] brightness;
  } panel_req_t;

  typedef struct packed {
    logic [5:0] x;
    logic [5:0] y;
  } pixel_xy_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic [63:0] in_tdata;   // [5:0] x, [11:6] y, [19:12] red, [27:20] green,
                           // [35:28] blue, [38:36] plane, [42:39] scan_row,
                           // [49:43] chain_column, [57:50] brightness
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] pin_byte

  // Our own copy of the frame store and the pin bytes still owed by the block.
  lpbs_pkg::rgb_t frame_model [0:STORE_DEPTH-1];
  logic [7:0] pending_pin_bytes[$];
  pixel_xy_t  recent_pixels[$];

  // Shared control between the stimulus and the result side.
  bit offering;       // in_tvalid is currently driven high
  bit steady;         // both sides run without idling
  int hold_off_len;   // a long receiver stall requested by a test

  int fault_count;
  int cycle_count;
  int write_count;
  int read_count;
  int scale_count;
  int clear_count;
  int checked_count;

  led_panel_bitplane_store uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung handshake: the run ends here if it ever gets this far.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d pin bytes outstanding.",
               cycle_count, pending_pin_bytes.size());
      $display("led_panel_bitplane_store: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Contribution of one pixel to a pin byte: its bit of the given plane for
  // each color, placed on that color's pin. Off-panel pixels add nothing.
  function automatic logic [7:0] pixel_pins(int row, int col, int plane,
                                            int rpin, int gpin, int bpin);
    logic [7:0]     pins;
    lpbs_pkg::rgb_t px;
    pins = 8'h00;
    if (row < 0 || row >= PANEL_SIZE || col < 0 || col >= PANEL_SIZE) return pins;
    px = frame_model[row * PANEL_SIZE + col];
    if (px.red[plane])   pins[rpin] = 1'b1;
    if (px.green[plane]) pins[gpin] = 1'b1;
    if (px.blue[plane])  pins[bpin] = 1'b1;
    return pins;
  endfunction

  // The second half of the chain runs left to right over the top half of the
  // panel; the first half runs right to left over the bottom half, upside down.
  function automatic logic [7:0] predict_pin_byte(logic [2:0] plane,
                                                  logic [3:0] srow,
                                                  logic [6:0] column);
    int col;
    int upper;
    int lower;
    if (int'(plane) >= PLANES || int'(srow) >= SCAN_ROWS ||
        int'(column) >= 2 * PANEL_SIZE) return 8'h00;
    if (int'(column) >= PANEL_SIZE) begin
      col   = int'(column) - PANEL_SIZE;
      upper = int'(srow);
      lower = int'(srow) + SCAN_ROWS;
    end else begin
      col   = PANEL_SIZE - 1 - int'(column);
      upper = PANEL_SIZE - 1 - int'(srow);
      lower = PANEL_SIZE - 1 - SCAN_ROWS - int'(srow);
    end
    return pixel_pins(upper, col, int'(plane), PIN_R1, PIN_G1, PIN_B1) |
           pixel_pins(lower, col, int'(plane), PIN_R2, PIN_G2, PIN_B2);
  endfunction

  // Updates the frame copy for one accepted transaction and queues the pin
  // byte that a read is owed.
  function automatic void apply_request(panel_req_t req);
    int             a;
    lpbs_pkg::rgb_t px;
    pixel_xy_t      p;
    case (req.kind)
      lpbs_pkg::REQ_WRITE: begin
        a = int'(req.y) * PANEL_SIZE + int'(req.x);
        frame_model[a] = {req.blue, req.green, req.red};
        p.x = req.x;
        p.y = req.y;
        recent_pixels.push_back(p);
        if (recent_pixels.size() > 16) void'(recent_pixels.pop_front());
        write_count++;
      end
      lpbs_pkg::REQ_READ: begin
        pending_pin_bytes.push_back(predict_pin_byte(req.plane, req.scan_row,
                                                     req.chain_column));
        read_count++;
      end
      lpbs_pkg::REQ_SCALE: begin
        for (a = 0; a < STORE_DEPTH; a++) begin
          px = frame_model[a];
          px.red   = 8'((int'(px.red)   * int'(req.brightness)) / 255);
          px.green = 8'((int'(px.green) * int'(req.brightness)) / 255);
          px.blue  = 8'((int'(px.blue)  * int'(req.brightness)) / 255);
          frame_model[a] = px;
        end
        scale_count++;
      end
      default: begin
        for (a = 0; a < STORE_DEPTH; a++) frame_model[a] = '0;
        clear_count++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int next_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] color_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Every field random, so that the fields a kind ignores still toggle.
  function automatic panel_req_t random_req(lpbs_pkg::req_t kind);
    panel_req_t r;
    r.kind         = kind;
    r.x            = 6'($urandom_range(0, 63));
    r.y            = 6'($urandom_range(0, 63));
    r.red          = color_value();
    r.green        = color_value();
    r.blue         = color_value();
    r.plane        = 3'($urandom_range(0, 7));
    r.scan_row     = 4'($urandom_range(0, 15));
    r.chain_column = 7'($urandom_range(0, 127));
    r.brightness   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Scan row and chain column at which a given pixel is shifted out.
  function automatic void locate_pixel(input logic [5:0] x, input logic [5:0] y,
                                       output logic [3:0] srow,
                                       output logic [6:0] column);
    if (int'(y) < SCAN_ROWS) begin
      srow   = 4'(int'(y));
      column = 7'(PANEL_SIZE + int'(x));
    end else if (int'(y) < 2 * SCAN_ROWS) begin
      srow   = 4'(int'(y) - SCAN_ROWS);
      column = 7'(PANEL_SIZE + int'(x));
    end else if (int'(y) < PANEL_SIZE - SCAN_ROWS) begin
      srow   = 4'(PANEL_SIZE - 1 - SCAN_ROWS - int'(y));
      column = 7'(PANEL_SIZE - 1 - int'(x));
    end else begin
      srow   = 4'(PANEL_SIZE - 1 - int'(y));
      column = 7'(PANEL_SIZE - 1 - int'(x));
    end
  endfunction

  function automatic panel_req_t write_of(logic [5:0] x, logic [5:0] y, logic [7:0] red,
                                          logic [7:0] green, logic [7:0] blue);
    panel_req_t r;
    r       = random_req(lpbs_pkg::REQ_WRITE);
    r.x     = x;
    r.y     = y;
    r.red   = red;
    r.green = green;
    r.blue  = blue;
    return r;
  endfunction

  function automatic panel_req_t read_of(logic [5:0] x, logic [5:0] y, logic [2:0] plane);
    panel_req_t r;
    r       = random_req(lpbs_pkg::REQ_READ);
    r.plane = plane;
    locate_pixel(x, y, r.scan_row, r.chain_column);
    return r;
  endfunction

  // Most reads land on a recently written pixel so that the bytes carry data;
  // the rest are fully random, out-of-range planes included.
  function automatic panel_req_t aimed_read();
    panel_req_t r;
    pixel_xy_t  p;
    r = random_req(lpbs_pkg::REQ_READ);
    if (recent_pixels.size() > 0 && $urandom_range(0, 9) < 7) begin
      p = recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
      locate_pixel(p.x, p.y, r.scan_row, r.chain_column);
      if ($urandom_range(0, 4) != 0) r.plane = 3'($urandom_range(0, PLANES - 1));
    end
    return r;
  endfunction

  // Mix of the random part: writes and reads, with a rare sweep since each one
  // walks the whole store.
  function automatic panel_req_t random_item();
    int pick;
    pick = $urandom_range(0, 999);
    if (pick < 440) return random_req(lpbs_pkg::REQ_WRITE);
    if (pick < 985) return aimed_read();
    if (pick < 995) return random_req(lpbs_pkg::REQ_SCALE);
    return random_req(lpbs_pkg::REQ_CLEAR);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  task automatic release_input();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offers one transaction after an optional gap and waits for the edge that
  // takes it. tvalid stays high afterwards so that back-to-back transactions
  // never see it dropped; any wait lowers it first.
  task automatic send_request(panel_req_t req, int gap);
    if (gap > 0) begin
      release_input();
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.kind;
    in_tdata  <= {6'b0, req.brightness, req.chain_column, req.scan_row, req.plane,
                  req.blue, req.green, req.red, req.y, req.x};
    offering = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(req);
  endtask

  // Stops offering and waits until every owed pin byte has come back.
  task automatic drain_results();
    release_input();
    while (pending_pin_bytes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver accepts in bursts with random stalls in between. A test can
  // ask for one long stall; its length is counted here.
  initial begin : result_receiver
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        stall = hold_off_len;
        hold_off_len = 0;
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        stall = next_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Every taken pin byte is matched against the oldest one still owed.
  always @(posedge clk) begin : pin_byte_checker
    logic [7:0] want_byte;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pin_bytes.size() == 0) begin
        $error("pin_byte: got %02h with no read outstanding", out_tdata);
        fault_count++;
      end else begin
        want_byte = pending_pin_bytes.pop_front();
        checked_count++;
        if (out_tdata !== want_byte) begin
          $error("pin_byte: expected %02h, actual %02h", want_byte, out_tdata);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The store comes out of reset black, at both ends of the chain.
  task automatic test_cleared_after_reset();
    panel_req_t r;
    r = random_req(lpbs_pkg::REQ_READ);
    r.plane = 3'd0;
    r.scan_row = 4'd0;
    r.chain_column = 7'd0;
    send_request(r, 0);
    r = random_req(lpbs_pkg::REQ_READ);
    r.plane = 3'(PLANES - 1);
    r.scan_row = 4'(SCAN_ROWS - 1);
    r.chain_column = 7'(2 * PANEL_SIZE - 1);
    send_request(r, next_gap());
    drain_results();
  endtask

  // One pixel in each quarter of the panel, three of them lighting one pin
  // each, plus an upper and a lower pixel that share one byte. Reads at every
  // plane from the first to the last and at planes past the last one.
  task automatic test_pixel_mapping();
    drain_results();
    send_request(write_of(6'd0,  6'd0,  8'hFF, 8'hFF, 8'hFF), next_gap());
    send_request(write_of(6'd63, 6'd31, 8'hFF, 8'h00, 8'h00), next_gap());
    send_request(write_of(6'd63, 6'd48, 8'h00, 8'hFF, 8'h00), next_gap());
    send_request(write_of(6'd0,  6'd47, 8'h00, 8'h00, 8'hFF), next_gap());
    send_request(write_of(6'd0,  6'd16, 8'h15, 8'h0A, 8'h1F), next_gap());
    send_request(read_of(6'd0,  6'd0,  3'd0), next_gap());
    send_request(read_of(6'd63, 6'd31, 3'd0), next_gap());
    send_request(read_of(6'd63, 6'd48, 3'd3), next_gap());
    send_request(read_of(6'd0,  6'd47, 3'(PLANES - 1)), next_gap());
    send_request(read_of(6'd0,  6'd16, 3'd1), next_gap());
    send_request(read_of(6'd0,  6'd16, 3'd2), next_gap());
    send_request(read_of(6'd0,  6'd0,  3'(PLANES)), next_gap());
    send_request(read_of(6'd0,  6'd0,  3'd7), next_gap());
    drain_results();
  endtask

  // Full brightness leaves the picture as it is; half brightness shifts
  // every value down by about one plane.
  task automatic test_scale_sweep();
    panel_req_t r;
    drain_results();
    r = random_req(lpbs_pkg::REQ_SCALE);
    r.brightness = 8'hFF;
    send_request(r, next_gap());
    send_request(read_of(6'd0, 6'd16, 3'd2), next_gap());
    r = random_req(lpbs_pkg::REQ_SCALE);
    r.brightness = 8'h80;
    send_request(r, next_gap());
    send_request(read_of(6'd0, 6'd16, 3'd0), next_gap());
    drain_results();
  endtask

  task automatic test_clear_sweep();
    drain_results();
    send_request(random_req(lpbs_pkg::REQ_CLEAR), next_gap());
    send_request(read_of(6'd0, 6'd0, 3'd0), next_gap());
    drain_results();
  endtask

  // The receiver stops for a long while as reads keep coming, so the output
  // register fills and the block has to hold off its input.
  task automatic test_output_backpressure();
    int i;
    drain_results();
    for (i = 0; i < 6; i++) send_request(random_req(lpbs_pkg::REQ_WRITE), 0);
    hold_off_len = 300;
    for (i = 0; i < 48; i++) send_request(aimed_read(), 0);
    drain_results();
  endtask

  task automatic test_steady_stream(int count);
    int i;
    drain_results();
    steady = 1'b1;
    for (i = 0; i < count; i++) send_request(random_item(), 0);
    drain_results();
    steady = 1'b0;
  endtask

  // Random traffic; now and then the sender waits for every owed byte.
  task automatic test_random_traffic(int count);
    int i;
    drain_results();
    for (i = 0; i < count; i++) begin
      send_request(random_item(), next_gap());
      if ($urandom_range(0, 199) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    offering     = 1'b0;
    steady       = 1'b0;
    hold_off_len = 0;
    foreach (frame_model[a]) frame_model[a] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The block runs its own clearing pass first; the first transaction simply
    // waits for in_tready.
    test_cleared_after_reset();
    test_pixel_mapping();
    test_scale_sweep();
    test_clear_sweep();
    test_output_backpressure();
    test_steady_stream(200);
    test_random_traffic(1470);

    drain_results();
    repeat (16) @(posedge clk);
    if (pending_pin_bytes.size() != 0) begin
      $error("pin_byte: %0d expected bytes never arrived", pending_pin_bytes.size());
      fault_count++;
    end

    $display("Covered %0d pixel writes, %0d pin byte reads, %0d scale and %0d clear sweeps.",
             write_count, read_count, scale_count, clear_count);
    $display("Checked %0d pin bytes under random and long output stalls, %0d cycles.",
             checked_count, cycle_count);
    if (fault_count == 0) begin
      $display("led_panel_bitplane_store: match");
    end else begin
      $display("led_panel_bitplane_store: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lpbs_pkg.sv
src/lpbs_frame_mem.sv
src/lpbs_scaler.sv
src/led_panel_bitplane_store.sv
test/tb_led_panel_bitplane_store.sv
